### rtl/energy_voice_activity_detector_macros.svh
// Assertion macros used by the voice activity detector RTL.
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_MACROS_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on clk outside of reset.
`define EVAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk outside of reset.
`define EVAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/evad_pkg.sv
// Types and constants shared by the voice activity detector modules.
package evad_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ENERGY_W = 32;
    localparam int HOLD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HANGOVER  = 2'd1;

    localparam logic [ENERGY_W-1:0] THRESHOLD_RESET = 32'd62500000;
    localparam logic [HOLD_W-1:0]   HANGOVER_RESET  = 16'd9600;

    localparam logic [1:0] EVT_NONE  = 2'd0;
    localparam logic [1:0] EVT_START = 2'd1;
    localparam logic [1:0] EVT_END   = 2'd2;

    typedef struct packed {
        logic [ENERGY_W-1:0] threshold;
        logic [HOLD_W-1:0]   hangover;
    } cfg_t;

endpackage

### rtl/evad_ring.sv
// Ring buffer memory with per-entry valid bits and a registered read port.
module evad_ring #(
    parameter int DEPTH = 50,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_q_reg;
    logic [DEPTH-1:0] filled_reg;
    logic             rd_filled_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            rd_filled_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                filled_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_filled_reg <= filled_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_filled_reg ? rd_q_reg : '0;

endmodule

### rtl/evad_mean.sv
// Running mean over the sample window and magnitude of the sample's deviation.
module evad_mean #(
    parameter int MEAN_WINDOW = 50
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
    output logic                              mag_valid,
    input  logic                              mag_ready,
    output logic [evad_pkg::SAMPLE_W-1:0]     mag
);

    import evad_pkg::*;

    localparam int AW      = $clog2(MEAN_WINDOW);
    localparam int SUM_W   = SAMPLE_W + AW;
    localparam int SHIFT   = SUM_W + AW;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // Reciprocal that gives exact floor division for any SUM_W-bit magnitude.
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / 64'(MEAN_WINDOW)) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [AW-1:0] LAST_IDX = AW'(MEAN_WINDOW - 1);

    // Stage 1: new sample with the sample it displaces from the ring.
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [AW-1:0]              s1_idx_reg;
    logic [AW-1:0]              rd_ptr_reg;
    logic [SAMPLE_W-1:0]        old_raw;
    // Stage 2: updated running sum.
    logic                       s2_valid_reg;
    logic signed [SAMPLE_W-1:0] s2_sample_reg;
    logic signed [SUM_W-1:0]    s2_sum_reg;
    logic signed [SUM_W-1:0]    sample_sum_reg;
    logic signed [SUM_W-1:0]    sample_sum_next;
    // Stage 3: reciprocal product of the sum magnitude.
    logic                       s3_valid_reg;
    logic signed [SAMPLE_W-1:0] s3_sample_reg;
    logic [PROD_W-1:0]          s3_prod_reg;
    logic                       s3_neg_reg;
    logic [SUM_W-1:0]           sum_mag;
    // Stage 4: deviation magnitude.
    logic                       s4_valid_reg;
    logic [SAMPLE_W-1:0]        s4_mag_reg;
    logic [SAMPLE_W-1:0]        quot;
    logic signed [SAMPLE_W+1:0] mean_s;
    logic signed [SAMPLE_W+1:0] dev_s;
    logic signed [SAMPLE_W+1:0] abs_dev;

    logic accept, move1, move2, move3, move4;
    logic free1, free2, free3, free4;

    assign move4 = s4_valid_reg && mag_ready;
    assign free4 = !s4_valid_reg || move4;
    assign move3 = s3_valid_reg && free4;
    assign free3 = !s3_valid_reg || move3;
    assign move2 = s2_valid_reg && free3;
    assign free2 = !s2_valid_reg || move2;
    assign move1 = s1_valid_reg && free2;
    assign free1 = !s1_valid_reg || move1;
    assign in_ready = free1;
    assign accept   = in_valid && free1;

    evad_ring #(
        .DEPTH (MEAN_WINDOW),
        .WIDTH (SAMPLE_W)
    ) u_sample_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_ptr_reg),
        .rd_data (old_raw),
        .wr_en   (move1),
        .wr_addr (s1_idx_reg),
        .wr_data (s1_sample_reg)
    );

    always_comb
    begin
        sample_sum_next = sample_sum_reg + SUM_W'(s1_sample_reg) - SUM_W'($signed(old_raw));
        sum_mag = s2_sum_reg[SUM_W-1] ? SUM_W'(-s2_sum_reg) : SUM_W'(s2_sum_reg);
        quot    = s3_prod_reg[SHIFT +: SAMPLE_W];
        mean_s  = s3_neg_reg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
        dev_s   = (SAMPLE_W + 2)'(s3_sample_reg) - mean_s;
        abs_dev = dev_s[SAMPLE_W+1] ? -dev_s : dev_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            rd_ptr_reg     <= '0;
            sample_sum_reg <= '0;
        end
        else
        begin
            if (free1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (accept)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (free2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (move1)
            begin
                sample_sum_reg <= sample_sum_next;
            end
            if (free3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (free4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_idx_reg    <= rd_ptr_reg;
        end
        if (move1)
        begin
            s2_sample_reg <= s1_sample_reg;
            s2_sum_reg    <= sample_sum_next;
        end
        if (move2)
        begin
            s3_sample_reg <= s2_sample_reg;
            s3_prod_reg   <= PROD_W'(sum_mag) * PROD_W'(RECIP);
            s3_neg_reg    <= s2_sum_reg[SUM_W-1];
        end
        if (move3)
        begin
            s4_mag_reg <= abs_dev[SAMPLE_W-1:0];
        end
    end

    assign mag_valid = s4_valid_reg;
    assign mag       = s4_mag_reg;

endmodule

### rtl/evad_energy.sv
// Squared deviation, windowed energy sum, threshold test and hangover control.
module evad_energy #(
    parameter int ENERGY_WINDOW = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  evad_pkg::cfg_t                cfg,
    input  logic                          mag_valid,
    output logic                          mag_ready,
    input  logic [evad_pkg::SAMPLE_W-1:0] mag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    event_res,
    output logic                          speech_active,
    output logic [evad_pkg::ENERGY_W-1:0] window_energy
);

    import evad_pkg::*;

    localparam int AW = $clog2(ENERGY_WINDOW);
    localparam logic [AW-1:0] LAST_IDX = AW'(ENERGY_WINDOW - 1);

    logic                s5_valid_reg;
    logic [ENERGY_W-1:0] s5_sq_reg;
    logic [AW-1:0]       s5_idx_reg;
    logic [AW-1:0]       rd_ptr_reg;
    logic [ENERGY_W-1:0] old_sq;

    logic [ENERGY_W-1:0] energy_sum_reg;
    logic [ENERGY_W-1:0] energy_sum_next;
    logic [HOLD_W-1:0]   hold_reg;
    logic [HOLD_W-1:0]   hold_next;
    logic                active_reg;
    logic                active_next;
    logic [1:0]          evt_next;
    logic [HOLD_W-1:0]   hold_load;
    logic [HOLD_W-1:0]   hold_dec;
    logic                speech;

    logic                out_valid_reg;
    logic [1:0]          out_evt_reg;
    logic                out_active_reg;
    logic [ENERGY_W-1:0] out_energy_reg;

    logic load5, move5, free5, free_out;

    assign free_out  = !out_valid_reg || out_ready;
    assign move5     = s5_valid_reg && free_out;
    assign free5     = !s5_valid_reg || move5;
    assign mag_ready = free5;
    assign load5     = mag_valid && free5;

    evad_ring #(
        .DEPTH (ENERGY_WINDOW),
        .WIDTH (ENERGY_W)
    ) u_square_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (load5),
        .rd_addr (rd_ptr_reg),
        .rd_data (old_sq),
        .wr_en   (move5),
        .wr_addr (s5_idx_reg),
        .wr_data (s5_sq_reg)
    );

    always_comb
    begin
        energy_sum_next = energy_sum_reg + s5_sq_reg - old_sq;
        speech    = energy_sum_next > cfg.threshold;
        hold_load = (cfg.hangover == '0) ? HOLD_W'(1) : cfg.hangover;
        hold_dec  = (hold_reg == '0) ? '0 : hold_reg - 1'b1;
        hold_next   = hold_reg;
        active_next = active_reg;
        evt_next    = EVT_NONE;
        if (active_reg)
        begin
            hold_next = hold_dec;
            // At expiry, speech re-arms the hangover; silence ends the segment.
            if (hold_dec == '0)
            begin
                if (speech)
                begin
                    hold_next = hold_load;
                end
                else
                begin
                    active_next = 1'b0;
                    evt_next    = EVT_END;
                end
            end
        end
        else if (speech)
        begin
            active_next = 1'b1;
            hold_next   = hold_load;
            evt_next    = EVT_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg   <= 1'b0;
            rd_ptr_reg     <= '0;
            energy_sum_reg <= '0;
            hold_reg       <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (free5)
            begin
                s5_valid_reg <= mag_valid;
            end
            if (load5)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (move5)
            begin
                energy_sum_reg <= energy_sum_next;
                hold_reg       <= hold_next;
                active_reg     <= active_next;
            end
            if (free_out)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load5)
        begin
            s5_sq_reg  <= ENERGY_W'(mag) * ENERGY_W'(mag);
            s5_idx_reg <= rd_ptr_reg;
        end
        if (move5)
        begin
            out_evt_reg    <= evt_next;
            out_active_reg <= active_next;
            out_energy_reg <= energy_sum_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = out_evt_reg;
    assign speech_active = out_active_reg;
    assign window_energy = out_energy_reg;

`include "energy_voice_activity_detector_macros.svh"

    `EVAD_ASSERT_NOW(a_active_has_hold, active_reg, hold_reg != '0, "active with empty hangover")
    `EVAD_ASSERT_NOW(a_start_is_active, out_valid_reg && out_evt_reg == EVT_START,
        out_active_reg, "speech start without active flag")
    `EVAD_ASSERT_NOW(a_end_is_idle, out_valid_reg && out_evt_reg == EVT_END,
        !out_active_reg, "speech end with active flag")
    `EVAD_ASSERT_NEXT(a_stall_holds_sum, s5_valid_reg && !free_out,
        $stable(energy_sum_reg), "energy sum moved while stalled")

endmodule

### rtl/energy_voice_activity_detector.sv
// Path: mean stages s1 to s4, energy stage s5, then the output register; any stage can stall.
// Throughput: one sample per cycle while out_ready is high; every stage holds one item and fills bubbles.
// The mean divide is a reciprocal multiply and each squaring has its own stage.
// Reset clears all control state and the ring valid bits at once; the block
// takes samples in the first cycle after reset, with no clearing pass.
module energy_voice_activity_detector #(
    parameter int MEAN_WINDOW   = 50,
    parameter int ENERGY_WINDOW = 50
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        event_res,
    output logic                              speech_active,
    output logic [evad_pkg::ENERGY_W-1:0]     window_energy,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [evad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import evad_pkg::*;

    cfg_t                cfg_reg;
    logic                mag_valid;
    logic                mag_ready;
    logic [SAMPLE_W-1:0] mag;

    assign cfg_ready = 1'b1;

    // Writes to an index outside the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= THRESHOLD_RESET;
            cfg_reg.hangover  <= HANGOVER_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_data[ENERGY_W-1:0];
                CFG_HANGOVER:  cfg_reg.hangover  <= cfg_data[HOLD_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    evad_mean #(
        .MEAN_WINDOW (MEAN_WINDOW)
    ) u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .mag_valid (mag_valid),
        .mag_ready (mag_ready),
        .mag       (mag)
    );

    evad_energy #(
        .ENERGY_WINDOW (ENERGY_WINDOW)
    ) u_energy (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .mag_valid     (mag_valid),
        .mag_ready     (mag_ready),
        .mag           (mag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_res     (event_res),
        .speech_active (speech_active),
        .window_energy (window_energy)
    );

endmodule
